>>> rtl/pmhc_pkg.sv
// Package for the model header checker: stream state, result codes and constants.
// Used by pmhc_csr, pmhc_step and protobuf_model_header_checker_unit.
package pmhc_pkg;

   localparam int unsigned CONT_BYTES_MAX = 4;
   localparam int unsigned IDX_W          = $clog2(CONT_BYTES_MAX + 1);

   localparam logic [7:0] CONT_BIT_MASK = 8'h80;

   localparam logic [2:0] WT_VARINT = 3'd0;
   localparam logic [2:0] WT_LENGTH = 3'd2;

   localparam logic [3:0] REQUIRED_RESET = 4'd3;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [0:0]  CSR_IDX_REQUIRED = 1'b0;

   typedef enum logic [3:0] {
      PH_KEY   = 4'b0001,
      PH_VALUE = 4'b0010,
      PH_LEN   = 4'b0100,
      PH_SKIP  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      R_OK     = 2'd0,
      R_BADKEY = 2'd1,
      R_DUP    = 2'd2,
      R_EARLY  = 2'd3
   } reason_type;

   typedef struct packed {
      phase_type        phase;
      logic [31:0]      length_accum;
      logic [IDX_W-1:0] varint_index;
      logic [31:0]      skip_left;
      logic [15:0]      seen_mask;
      logic [3:0]       found_count;
      logic             verdict_given;
      logic [3:0]       pending_field;
   } stream_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_start;
      logic       stream_end;
   } item_type;

   typedef struct packed {
      logic       is_valid;
      reason_type reason;
      logic [3:0] fields_found;
   } verdict_type;

   localparam stream_state_type STATE_CLEAR = '{
      phase:         PH_KEY,
      length_accum:  32'd0,
      varint_index:  '0,
      skip_left:     32'd0,
      seen_mask:     16'd0,
      found_count:   4'd0,
      verdict_given: 1'b0,
      pending_field: 4'd0
   };

   function automatic logic is_length_field(input logic [3:0] f);
      logic r;
      case (f)
         4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd14: r = 1'b1;
         default:                                   r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/pmhc_csr.sv
// Configuration register file for the model header checker (APB-style port).
// Depends on pmhc_pkg.
module pmhc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pmhc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output logic [3:0]                       required_fields
);
   import pmhc_pkg::*;

   logic [3:0] required_ff;
   logic [3:0] required_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      required_in = required_ff;
      if (wr_en && (csr_paddr[2] == CSR_IDX_REQUIRED)) begin
         required_in = csr_pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         required_ff <= REQUIRED_RESET;
      end else begin
         required_ff <= required_in;
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == CSR_IDX_REQUIRED) begin
         csr_prdata = {28'd0, required_ff};
      end
   end

   assign required_fields = required_ff;

endmodule

>>> rtl/pmhc_step.sv
// Per-byte decode of the protobuf key/varint/payload state and verdict logic.
// Depends on pmhc_pkg.
module pmhc_step (
   input  pmhc_pkg::stream_state_type cur_state,
   input  pmhc_pkg::item_type         item,
   input  logic [3:0]                 required_fields,
   output pmhc_pkg::stream_state_type next_state,
   output logic                       res_valid,
   output pmhc_pkg::verdict_type      result
);
   import pmhc_pkg::*;

   stream_state_type s;
   stream_state_type n;
   logic [7:0]       b;
   logic [3:0]       f;
   logic [2:0]       wt;
   logic             good;
   logic             last;
   logic [7:0]       part;
   logic [5:0]       shamt;
   logic [31:0]      accum;
   logic [15:0]      bit_sel;
   logic [3:0]       cnt;

   always_comb begin
      s         = item.stream_start ? STATE_CLEAR : cur_state;
      n         = s;
      b         = item.data_byte;
      f         = b[6:3];
      wt        = b[2:0];
      good      = 1'b0;
      last      = (32'(s.varint_index) >= CONT_BYTES_MAX) || ((b & CONT_BIT_MASK) == 8'd0);
      part      = last ? b : {1'b0, b[6:0]};
      shamt     = 6'(s.varint_index) * 6'd7;
      accum     = s.length_accum | (32'(part) << shamt);
      bit_sel   = 16'd1 << s.pending_field;
      cnt       = s.found_count + 4'd1;
      res_valid = 1'b0;
      result    = '{is_valid: 1'b0, reason: R_OK, fields_found: s.found_count};

      if (!s.verdict_given) begin
         if (required_fields == 4'd0) begin
            res_valid       = 1'b1;
            result.is_valid = 1'b1;
            n.verdict_given = 1'b1;
         end else begin
            unique case (s.phase)
               PH_KEY: begin
                  if ((b & CONT_BIT_MASK) == 8'd0) begin
                     if (f == 4'd1 || f == 4'd5) begin
                        good    = (wt == WT_VARINT);
                        n.phase = PH_VALUE;
                     end else if (is_length_field(f)) begin
                        good    = (wt == WT_LENGTH);
                        n.phase = PH_LEN;
                     end
                  end
                  if (!good) begin
                     n.phase         = PH_KEY;
                     res_valid       = 1'b1;
                     result.reason   = R_BADKEY;
                     n.verdict_given = 1'b1;
                  end else begin
                     n.pending_field = f;
                     n.length_accum  = 32'd0;
                     n.varint_index  = '0;
                  end
               end
               PH_VALUE, PH_LEN: begin
                  n.length_accum = accum;
                  if (!last) begin
                     n.varint_index = s.varint_index + 1'b1;
                  end else begin
                     n.varint_index = '0;
                     if ((s.seen_mask & bit_sel) != 16'd0) begin
                        res_valid       = 1'b1;
                        result.reason   = R_DUP;
                        n.verdict_given = 1'b1;
                     end else begin
                        n.seen_mask   = s.seen_mask | bit_sel;
                        n.found_count = cnt;
                        if (cnt >= required_fields) begin
                           res_valid           = 1'b1;
                           result.is_valid     = 1'b1;
                           result.fields_found = cnt;
                           n.verdict_given     = 1'b1;
                        end else if (s.phase == PH_LEN && accum != 32'd0) begin
                           n.skip_left = accum;
                           n.phase     = PH_SKIP;
                        end else begin
                           n.phase = PH_KEY;
                        end
                     end
                  end
               end
               PH_SKIP: begin
                  n.skip_left = s.skip_left - 32'd1;
                  if (s.skip_left == 32'd1) begin
                     n.phase = PH_KEY;
                  end
               end
               default: begin
                  n.phase = PH_KEY;
               end
            endcase
         end
      end

      if (item.stream_end) begin
         if (!n.verdict_given) begin
            res_valid = 1'b1;
            result    = '{is_valid: 1'b0, reason: R_EARLY, fields_found: n.found_count};
         end
         n = STATE_CLEAR;
      end

      next_state = n;
   end

endmodule

>>> rtl/protobuf_model_header_checker_unit.sv
// Top level of the model header checker: input register, decode step, result register.
// Depends on pmhc_pkg, pmhc_csr and pmhc_step.
//
// Usage:
//   req channel carries one stream byte per transaction; tuser marks the first
//   byte of a stream (clears the decode state), tlast marks the last byte.
//   rsp channel carries at most one verdict per stream: is_valid, reason
//   (ok, bad key or wire type, duplicate field, ended early) and the number of
//   distinct fields found. Bytes after a verdict give nothing until the stream
//   ends or restarts; a stream end without a verdict gives an "ended early" one.
//   The csr port holds required_fields at address 0 (reset value 3).
// Timing:
//   A byte is registered on acceptance and decoded from the input register;
//   its verdict is registered in the result register. One byte per cycle is
//   sustained while rsp takes verdicts; the state update is one pass per byte.
//   When rsp stalls with a verdict held, the input register still takes a byte;
//   req_tready drops only while both the input and result registers are full.
// Reset:
//   Synchronous, active high; clears the stream state, both valid flags and
//   sets required_fields back to 3.
module protobuf_model_header_checker_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // [7:0] data_byte
   input  logic                             req_tuser,   // [0] stream_start
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,   // [0] is_valid, [2:1] reason,
                                                         // [6:3] fields_found, [7] zero
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pmhc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import pmhc_pkg::*;

   logic [3:0]       required_fields;

   logic             in_valid_ff;
   logic             in_valid_in;
   item_type         item_ff;

   stream_state_type state_ff;
   stream_state_type state_in;
   stream_state_type step_state;

   logic             step_res_valid;
   verdict_type      step_result;

   logic             out_valid_ff;
   logic             out_valid_in;
   verdict_type      out_ff;

   logic             fire;
   logic             req_fire;

   pmhc_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .required_fields (required_fields)
   );

   pmhc_step u_step (
      .cur_state       (state_ff),
      .item            (item_ff),
      .required_fields (required_fields),
      .next_state      (step_state),
      .res_valid       (step_res_valid),
      .result          (step_result)
   );

   assign fire       = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | fire;
   assign req_fire   = req_tvalid & req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (fire && step_res_valid) begin
         out_valid_in = 1'b1;
      end
   end

   assign state_in = fire ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= '{data_byte: req_tdata, stream_start: req_tuser, stream_end: req_tlast};
      end
      if (fire && step_res_valid) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.fields_found, out_ff.reason, out_ff.is_valid};

endmodule
